// File: src/mesh_edge_adjacency_table_unit_macros.svh
// Assertion macros for the mesh edge adjacency table unit checker.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef MESH_EDGE_ADJACENCY_TABLE_UNIT_MACROS_SVH
`define MESH_EDGE_ADJACENCY_TABLE_UNIT_MACROS_SVH

// Check a property while out of reset.
`define MEAT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define MEAT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: src/meat_pkg.sv
// Shared types and constants of the mesh edge adjacency table unit.
// No dependencies.
`default_nettype none

package meat_pkg;

    localparam int MAX_EDGES_DEF = 256;

    localparam int VERT_W  = 16;
    localparam int FACE_W  = 16;
    localparam int INDEX_W = 8;
    localparam int TOTAL_W = 9;
    localparam int ADDED_W = 2;
    localparam int FUNC_W  = 2;
    localparam int ENTRY_W = 2 * VERT_W + 2 * FACE_W;

    localparam logic [FACE_W-1:0] NO_FACE  = 16'hffff;
    localparam logic [FACE_W-1:0] FACE_SAT = 16'd65534;

    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        KIND_ADD,
        KIND_READ,
        KIND_CLEAR,
        KIND_NOP
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [VERT_W-1:0]  vert_a;
        logic [VERT_W-1:0]  vert_b;
        logic [VERT_W-1:0]  vert_c;
        logic [FACE_W-1:0]  face;
        logic [INDEX_W-1:0] edge_index;
    } t_cmd;

    typedef struct packed {
        logic               overflow;
        logic [ADDED_W-1:0] edges_added;
        logic [TOTAL_W-1:0] edge_total;
        logic [FACE_W-1:0]  second_face;
        logic [FACE_W-1:0]  first_face;
        logic [VERT_W-1:0]  edge_vert_hi;
        logic [VERT_W-1:0]  edge_vert_lo;
    } t_result;

endpackage

`default_nettype wire

// File: src/mesh_edge_adjacency_table_unit.sv
// Top level of the mesh edge adjacency table unit.
// Depends on meat_pkg, meat_front, meat_queue and meat_back.
//
// Usage:
//   Input stream words carry a function code in tuser (add triangle, read
//   entry, clear) and the vertex indices and read index in tdata. Every
//   input word yields exactly one output word, in order.
//   A front end numbers faces and feeds a two-entry command queue, so up to
//   two words are taken while the back end works or the output is stalled.
//   An add scans the edge memory once per triangle edge, one entry per cycle
//   on its single read port, and a scan stops early when the edge is found.
//   A read passes through a read state; a clear or an unknown code is
//   answered directly from idle.
//   The result sits in an output register until the receiver takes it;
//   while it stalls, the back end waits and the queue fills, then tready
//   drops. Reset empties the table and the queue and zeroes the face
//   counter at once; memory contents stay as they are and are never used
//   past the edge count, so no clearing pass is needed.
`default_nettype none

module mesh_edge_adjacency_table_unit #(
    parameter int MAX_EDGES = meat_pkg::MAX_EDGES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // vert_a, vert_b, vert_c, edge_index
    input  wire logic [55:0] i_s_axis_tdata,
    // func
    input  wire logic [1:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // edge_vert_lo, edge_vert_hi, first_face, second_face, edge_total,
    // edges_added, overflow, zero pad
    output logic [79:0]      o_m_axis_tdata
);
    import meat_pkg::*;

    logic    q_full;
    logic    push;
    t_cmd    push_cmd;
    logic    q_valid;
    t_cmd    q_cmd;
    logic    q_pop;
    t_result res;

    meat_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_push_cmd      (push_cmd)
    );

    meat_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_cmd      (q_cmd),
        .i_pop      (q_pop)
    );

    meat_back #(
        .MAX_EDGES (MAX_EDGES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_res_valid (o_m_axis_tvalid),
        .o_res       (res),
        .i_res_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {4'b0000, res};

endmodule

`default_nettype wire

// File: src/meat_front.sv
// Front end: decodes input words into commands and numbers the faces.
// Depends on meat_pkg.
`default_nettype none

module meat_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  wire logic [55:0]               i_s_axis_tdata,
    input  wire logic [meat_pkg::FUNC_W-1:0] i_s_axis_tuser,
    input  wire logic                      i_q_full,
    output logic                           o_push,
    output meat_pkg::t_cmd                 o_push_cmd
);
    import meat_pkg::*;

    logic [FACE_W-1:0] r_face;
    logic [FACE_W-1:0] n_face;
    t_kind             kind;

    always_comb begin
        unique case (i_s_axis_tuser)
            FUNC_ADD:   kind = KIND_ADD;
            FUNC_READ:  kind = KIND_READ;
            FUNC_CLEAR: kind = KIND_CLEAR;
            default:    kind = KIND_NOP;
        endcase
    end

    assign o_s_axis_tready = !i_q_full;
    assign o_push          = i_s_axis_tvalid && !i_q_full;

    always_comb begin
        o_push_cmd.kind       = kind;
        o_push_cmd.vert_a     = i_s_axis_tdata[15:0];
        o_push_cmd.vert_b     = i_s_axis_tdata[31:16];
        o_push_cmd.vert_c     = i_s_axis_tdata[47:32];
        o_push_cmd.edge_index = i_s_axis_tdata[55:48];
        o_push_cmd.face       = r_face;
    end

    always_comb begin
        n_face = r_face;
        if (o_push) begin
            case (kind)
                KIND_ADD:   n_face = (r_face < FACE_SAT) ? r_face + 1'b1 : r_face;
                KIND_CLEAR: n_face = '0;
                default:    n_face = r_face;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face <= '0;
        end else begin
            r_face <= n_face;
        end
    end

endmodule

`default_nettype wire

// File: src/meat_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on meat_pkg.
`default_nettype none

module meat_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  meat_pkg::t_cmd      i_push_cmd,
    output logic                o_full,
    output logic                o_valid,
    output meat_pkg::t_cmd      o_cmd,
    input  wire logic           i_pop
);
    import meat_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: src/meat_back.sv
// Back end: scans the edge memory per triangle edge, appends or links edges,
// serves reads and clears, and holds the result register. Depends on meat_pkg.
`default_nettype none

module meat_back #(
    parameter int MAX_EDGES = meat_pkg::MAX_EDGES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  meat_pkg::t_cmd      i_q_cmd,
    output logic                o_q_pop,
    output logic                o_res_valid,
    output meat_pkg::t_result   o_res,
    input  wire logic           i_res_ready
);
    import meat_pkg::*;

    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;

    localparam logic [1:0] EDGE_AB = 2'd0;
    localparam logic [1:0] EDGE_BC = 2'd1;
    localparam logic [1:0] EDGE_AC = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_READ
    } t_state;

    logic [ENTRY_W-1:0] mem [MAX_EDGES];
    logic [ENTRY_W-1:0] r_rd_data;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;

    t_state             r_state,     n_state;
    t_cmd               r_cmd,       n_cmd;
    logic [1:0]         r_edge_sel,  n_edge_sel;
    logic [CW-1:0]      r_count,     n_count;
    logic [CW-1:0]      r_issue,     n_issue;
    logic               r_rd_valid,  n_rd_valid;
    logic [AW-1:0]      r_rd_idx,    n_rd_idx;
    logic               r_hit,       n_hit;
    logic [AW-1:0]      r_hit_idx,   n_hit_idx;
    logic [ENTRY_W-1:0] r_hit_data,  n_hit_data;
    logic [ADDED_W-1:0] r_added,     n_added;
    logic               r_ovf,       n_ovf;
    logic               r_in_range,  n_in_range;
    logic               r_out_valid, n_out_valid;
    t_result            r_out,       n_out;

    logic [VERT_W-1:0]  u;
    logic [VERT_W-1:0]  v;
    logic [VERT_W-1:0]  rd_lo;
    logic [VERT_W-1:0]  rd_hi;
    logic               rd_match;
    logic               full;
    logic [IW-1:0]      idx_w;
    logic [IW-1:0]      count_w;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    always_comb begin
        case (r_edge_sel)
            EDGE_AB: begin
                u = r_cmd.vert_a;
                v = r_cmd.vert_b;
            end
            EDGE_BC: begin
                u = r_cmd.vert_b;
                v = r_cmd.vert_c;
            end
            default: begin
                u = r_cmd.vert_a;
                v = r_cmd.vert_c;
            end
        endcase
    end

    assign rd_lo    = r_rd_data[VERT_W-1:0];
    assign rd_hi    = r_rd_data[2*VERT_W-1:VERT_W];
    assign rd_match = (rd_lo == u && rd_hi == v) || (rd_lo == v && rd_hi == u);
    assign full     = (r_count == CW'(MAX_EDGES));
    assign idx_w    = IW'(i_q_cmd.edge_index);
    assign count_w  = IW'(r_count);

    assign o_q_pop     = (r_state == ST_IDLE) && i_q_valid && !r_out_valid;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_edge_sel  = r_edge_sel;
        n_count     = r_count;
        n_issue     = r_issue;
        n_rd_valid  = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_data  = r_hit_data;
        n_added     = r_added;
        n_ovf       = r_ovf;
        n_in_range  = r_in_range;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out       = r_out;
        mem_re      = 1'b0;
        mem_raddr   = r_issue[AW-1:0];
        mem_we      = 1'b0;
        mem_waddr   = r_hit_idx;
        mem_wdata   = r_hit_data;

        unique case (r_state)
            ST_IDLE: begin
                if (o_q_pop) begin
                    n_cmd      = i_q_cmd;
                    n_edge_sel = EDGE_AB;
                    n_issue    = '0;
                    n_added    = '0;
                    n_ovf      = 1'b0;
                    n_out      = '0;
                    unique case (i_q_cmd.kind)
                        KIND_ADD: begin
                            n_state = ST_SCAN;
                        end
                        KIND_READ: begin
                            n_in_range = (idx_w < count_w);
                            mem_re     = 1'b1;
                            mem_raddr  = idx_w[AW-1:0];
                            n_state    = ST_READ;
                        end
                        KIND_CLEAR: begin
                            n_count                = '0;
                            n_out.second_face      = '0;
                            n_out.edge_total       = '0;
                            n_out_valid            = 1'b1;
                        end
                        default: begin
                            n_out.edge_total = TOTAL_W'(r_count);
                            n_out_valid      = 1'b1;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (r_rd_valid && rd_match) begin
                    n_hit      = 1'b1;
                    n_hit_idx  = r_rd_idx;
                    n_hit_data = r_rd_data;
                    n_state    = ST_APPLY;
                end else if (r_issue < r_count) begin
                    mem_re     = 1'b1;
                    n_issue    = r_issue + 1'b1;
                    n_rd_valid = 1'b1;
                    n_rd_idx   = r_issue[AW-1:0];
                end else if (!r_rd_valid) begin
                    n_hit   = 1'b0;
                    n_state = ST_APPLY;
                end
            end

            ST_APPLY: begin
                if (r_hit) begin
                    if (r_hit_data[ENTRY_W-1:ENTRY_W-FACE_W] == NO_FACE &&
                        r_hit_data[2*VERT_W+FACE_W-1:2*VERT_W] != r_cmd.face) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_hit_idx;
                        mem_wdata = {r_cmd.face, r_hit_data[2*VERT_W+FACE_W-1:0]};
                    end
                end else if (!full) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_count[AW-1:0];
                    mem_wdata = {NO_FACE, r_cmd.face, v, u};
                    n_count   = r_count + 1'b1;
                    n_added   = r_added + 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
                n_hit   = 1'b0;
                n_issue = '0;
                if (r_edge_sel == EDGE_AC) begin
                    n_out.edge_total  = TOTAL_W'(n_count);
                    n_out.edges_added = n_added;
                    n_out.overflow    = n_ovf;
                    n_out_valid       = 1'b1;
                    n_state           = ST_IDLE;
                end else begin
                    n_edge_sel = r_edge_sel + 2'd1;
                    n_state    = ST_SCAN;
                end
            end

            ST_READ: begin
                if (r_in_range) begin
                    n_out.edge_vert_lo = rd_lo;
                    n_out.edge_vert_hi = rd_hi;
                    n_out.first_face   = r_rd_data[2*VERT_W+FACE_W-1:2*VERT_W];
                    n_out.second_face  = r_rd_data[ENTRY_W-1:ENTRY_W-FACE_W];
                end else begin
                    n_out.second_face  = NO_FACE;
                end
                n_out.edge_total = TOTAL_W'(r_count);
                n_out_valid      = 1'b1;
                n_state          = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_valid  <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
            r_edge_sel  <= EDGE_AB;
            r_issue     <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_valid  <= n_rd_valid;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
            r_edge_sel  <= n_edge_sel;
            r_issue     <= n_issue;
        end
        r_cmd      <= n_cmd;
        r_rd_idx   <= n_rd_idx;
        r_hit_idx  <= n_hit_idx;
        r_hit_data <= n_hit_data;
        r_added    <= n_added;
        r_ovf      <= n_ovf;
        r_in_range <= n_in_range;
        r_out      <= n_out;
    end

endmodule

`default_nettype wire

// File: src/meat_checker.sv
// Port-level checker for the mesh edge adjacency table unit, with its bind.
// Depends on mesh_edge_adjacency_table_unit_macros.svh.
`default_nettype none

`include "mesh_edge_adjacency_table_unit_macros.svh"

module meat_checker #(
    parameter int MAX_EDGES = 256
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [55:0] i_s_axis_tdata,
    input wire logic [1:0]  i_s_axis_tuser,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [79:0] o_m_axis_tdata
);

    `MEAT_ASSERT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "output word changed while stalled")
    `MEAT_ASSERT_ALWAYS(a_rst_out, !i_rst_n |=> !o_m_axis_tvalid, "output valid right after reset")
    `MEAT_ASSERT_ALWAYS(a_rst_ready, !i_rst_n |=> o_s_axis_tready, "input not ready right after reset")
    `MEAT_ASSERT(a_ovf_full, o_m_axis_tvalid && o_m_axis_tdata[75] |-> o_m_axis_tdata[72:64] == 9'(MAX_EDGES), "overflow reported with table not full")

endmodule

bind mesh_edge_adjacency_table_unit meat_checker #(
    .MAX_EDGES (MAX_EDGES)
) u_meat_checker (.*);

`default_nettype wire

// File: verif/mesh_edge_adjacency_table_unit_test.sv
// Self-checking testbench for the mesh edge adjacency table unit: directed table and
// random mesh phases, each output word checked against typed values or a predictor.
// Depends on meat_pkg and mesh_edge_adjacency_table_unit.
module mesh_edge_adjacency_table_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import meat_pkg::*;

    localparam int TBL_DEPTH      = MAX_EDGES_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 800;
    localparam int HOLD_CYCLES    = 300;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam bit TYPED = 1'b1;
    localparam bit PRED  = 1'b0;

    typedef enum logic [1:0] {
        EDGE_MATCHED,
        EDGE_APPENDED,
        EDGE_DROPPED
    } t_edge_fate;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [VERT_W-1:0]  vert_a;
        logic [VERT_W-1:0]  vert_b;
        logic [VERT_W-1:0]  vert_c;
        logic [INDEX_W-1:0] edge_index;
    } t_cmd_word;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [VERT_W-1:0]  vert_a;
        logic [VERT_W-1:0]  vert_b;
        logic [VERT_W-1:0]  vert_c;
        logic [INDEX_W-1:0] edge_index;
        logic               typed;
        logic [VERT_W-1:0]  lo;
        logic [VERT_W-1:0]  hi;
        logic [FACE_W-1:0]  f0;
        logic [FACE_W-1:0]  f1;
        logic [TOTAL_W-1:0] total;
        logic [ADDED_W-1:0] added;
        logic               ovf;
    } t_row;

    // func, a, b, c, index, typed, lo, hi, first, second, total, added, overflow
    localparam t_row DIRECTED [24] = '{
        '{FUNC_READ,   16'h0,    16'h0,    16'h0,    8'h00, TYPED,
          16'h0, 16'h0, 16'h0, NO_FACE, 9'd0, 2'd0, 1'b0},
        '{FUNC_UNUSED, 16'hffff, 16'hffff, 16'hffff, 8'hff, TYPED,
          16'h0, 16'h0, 16'h0, 16'h0,   9'd0, 2'd0, 1'b0},
        '{FUNC_CLEAR,  16'h0,    16'h0,    16'h0,    8'h00, TYPED,
          16'h0, 16'h0, 16'h0, 16'h0,   9'd0, 2'd0, 1'b0},
        '{FUNC_ADD,    16'hffff, 16'h0,    16'hffff, 8'h00, PRED,
          16'h0, 16'h0, 16'h0, 16'h0,   9'd0, 2'd0, 1'b0},
        '{FUNC_READ,   16'h0,    16'h0,    16'h0,    8'h00, TYPED,
          16'hffff, 16'h0, 16'h0, NO_FACE, 9'd2, 2'd0, 1'b0},
        '{FUNC_READ,   16'h0,    16'h0,    16'h0,    8'h01, PRED,
          16'h0, 16'h0, 16'h0, 16'h0,   9'd0, 2'd0, 1'b0},
        '{FUNC_ADD,    16'h0,    16'hffff, 16'h1,    8'h00, PRED,
          16'h0, 16'h0, 16'h0, 16'h0,   9'd0, 2'd0, 1'b0},
        '{FUNC_READ,   16'h0,    16'h0,    16'h0,    8'h00, PRED,
          16'h0, 16'h0, 16'h0, 16'h0,   9'd0, 2'd0, 1'b0},
        '{FUNC_READ,   16'h0,    16'h0,    16'h0,    8'hff, TYPED,
          16'h0, 16'h0, 16'h0, NO_FACE, 9'd4, 2'd0, 1'b0},
        '{FUNC_READ,   16'h0,    16'h0,    16'h0,    8'h04, TYPED,
          16'h0, 16'h0, 16'h0, NO_FACE, 9'd4, 2'd0, 1'b0},
        '{FUNC_ADD,    16'h5,    16'h5,    16'h5,    8'h00, PRED,
          16'h0, 16'h0, 16'h0, 16'h0,   9'd0, 2'd0, 1'b0},
        '{FUNC_ADD,    16'h5,    16'h5,    16'h6,    8'h00, PRED,
          16'h0, 16'h0, 16'h0, 16'h0,   9'd0, 2'd0, 1'b0},
        '{FUNC_READ,   16'h0,    16'h0,    16'h0,    8'h04, PRED,
          16'h0, 16'h0, 16'h0, 16'h0,   9'd0, 2'd0, 1'b0},
        '{FUNC_READ,   16'h0,    16'h0,    16'h0,    8'h03, PRED,
          16'h0, 16'h0, 16'h0, 16'h0,   9'd0, 2'd0, 1'b0},
        '{FUNC_ADD,    16'haaaa, 16'h5555, 16'h00ff, 8'h00, PRED,
          16'h0, 16'h0, 16'h0, 16'h0,   9'd0, 2'd0, 1'b0},
        '{FUNC_ADD,    16'h5555, 16'haaaa, 16'h1234, 8'h00, PRED,
          16'h0, 16'h0, 16'h0, 16'h0,   9'd0, 2'd0, 1'b0},
        '{FUNC_READ,   16'h0,    16'h0,    16'h0,    8'h07, PRED,
          16'h0, 16'h0, 16'h0, 16'h0,   9'd0, 2'd0, 1'b0},
        '{FUNC_UNUSED, 16'h1234, 16'h5678, 16'h9abc, 8'h5a, PRED,
          16'h0, 16'h0, 16'h0, 16'h0,   9'd0, 2'd0, 1'b0},
        '{FUNC_CLEAR,  16'hffff, 16'hffff, 16'hffff, 8'hff, TYPED,
          16'h0, 16'h0, 16'h0, 16'h0,   9'd0, 2'd0, 1'b0},
        '{FUNC_READ,   16'h0,    16'h0,    16'h0,    8'h00, TYPED,
          16'h0, 16'h0, 16'h0, NO_FACE, 9'd0, 2'd0, 1'b0},
        '{FUNC_ADD,    16'h1,    16'h2,    16'h3,    8'h00, TYPED,
          16'h0, 16'h0, 16'h0, 16'h0,   9'd3, 2'd3, 1'b0},
        '{FUNC_READ,   16'h0,    16'h0,    16'h0,    8'h00, TYPED,
          16'h1, 16'h2, 16'h0, NO_FACE, 9'd3, 2'd0, 1'b0},
        '{FUNC_ADD,    16'h3,    16'h2,    16'h4,    8'h00, PRED,
          16'h0, 16'h0, 16'h0, 16'h0,   9'd0, 2'd0, 1'b0},
        '{FUNC_READ,   16'h0,    16'h0,    16'h0,    8'h01, PRED,
          16'h0, 16'h0, 16'h0, 16'h0,   9'd0, 2'd0, 1'b0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [55:0] s_data = '0;
    logic [1:0]  s_user = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [79:0] m_data;

    logic [VERT_W-1:0] tbl_lo     [TBL_DEPTH];
    logic [VERT_W-1:0] tbl_hi     [TBL_DEPTH];
    logic [FACE_W-1:0] tbl_first  [TBL_DEPTH];
    logic [FACE_W-1:0] tbl_second [TBL_DEPTH];
    int                tbl_count = 0;
    logic [FACE_W-1:0] face_num = '0;

    t_result pending_results[$];
    int      n_errors = 0;
    int      quiet_cycles = 0;
    int      send_idle = 0;
    int      recv_stall = 0;
    int      pressure_req = 0;
    int      pressure_seen = 0;
    int      hold_left = 0;

    mesh_edge_adjacency_table_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always #1 clk = ~clk;

    function automatic t_edge_fate place_edge(logic [VERT_W-1:0] u, logic [VERT_W-1:0] v,
                                              logic [FACE_W-1:0] face);
        for (int i = 0; i < tbl_count; i++) begin
            if ((tbl_lo[i] == u && tbl_hi[i] == v) || (tbl_lo[i] == v && tbl_hi[i] == u)) begin
                if (tbl_second[i] == NO_FACE && tbl_first[i] != face) begin
                    tbl_second[i] = face;
                end
                return EDGE_MATCHED;
            end
        end
        if (tbl_count >= TBL_DEPTH) begin
            return EDGE_DROPPED;
        end
        tbl_lo[tbl_count]     = u;
        tbl_hi[tbl_count]     = v;
        tbl_first[tbl_count]  = face;
        tbl_second[tbl_count] = NO_FACE;
        tbl_count++;
        return EDGE_APPENDED;
    endfunction

    function automatic t_result table_step(t_cmd_word w);
        t_result           r;
        logic [FACE_W-1:0] face;
        t_edge_fate        fate [3];
        r = '0;
        case (w.func)
            FUNC_ADD: begin
                face = face_num;
                if (face_num < FACE_SAT) begin
                    face_num = face_num + 1'b1;
                end
                fate[0] = place_edge(w.vert_a, w.vert_b, face);
                fate[1] = place_edge(w.vert_b, w.vert_c, face);
                fate[2] = place_edge(w.vert_a, w.vert_c, face);
                foreach (fate[i]) begin
                    if (fate[i] == EDGE_APPENDED) begin
                        r.edges_added = r.edges_added + 1'b1;
                    end else if (fate[i] == EDGE_DROPPED) begin
                        r.overflow = 1'b1;
                    end
                end
            end
            FUNC_READ: begin
                if (int'(w.edge_index) < tbl_count) begin
                    r.edge_vert_lo = tbl_lo[w.edge_index];
                    r.edge_vert_hi = tbl_hi[w.edge_index];
                    r.first_face   = tbl_first[w.edge_index];
                    r.second_face  = tbl_second[w.edge_index];
                end else begin
                    r.second_face = NO_FACE;
                end
            end
            FUNC_CLEAR: begin
                tbl_count = 0;
                face_num  = '0;
            end
            default: begin
            end
        endcase
        r.edge_total = TOTAL_W'(tbl_count);
        return r;
    endfunction

    task automatic send_word(input t_cmd_word w, input bit typed, input t_result typed_res);
        t_result r;
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {w.edge_index, w.vert_c, w.vert_b, w.vert_a};
        s_user  <= w.func;
        @(posedge clk);
        while (!s_ready) begin
            @(posedge clk);
        end
        r = table_step(w);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic send_tri(input logic [VERT_W-1:0] a, b, c);
        send_word('{FUNC_ADD, a, b, c, 8'h0}, PRED, '0);
    endtask

    task automatic send_read(input logic [INDEX_W-1:0] idx);
        send_word('{FUNC_READ, 16'h0, 16'h0, 16'h0, idx}, PRED, '0);
    endtask

    task automatic send_clear();
        send_word('{FUNC_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom)},
                  PRED, '0);
    endtask

    function automatic logic [INDEX_W-1:0] stored_index();
        return INDEX_W'($urandom_range(0, (tbl_count > 255) ? 255 : tbl_count));
    endfunction

    // Strip of triangles that overruns the table, then revisits stored edges.
    task automatic fill_table();
        int                base;
        int                k;
        logic [VERT_W-1:0] v;
        base = $urandom_range(0, 60000);
        send_clear();
        for (k = 0; k < 140; k++) begin
            v = VERT_W'(base + k);
            send_tri(v, v + 16'd1, v + 16'd2);
            if (k % 8 == 7) begin
                send_read(stored_index());
            end
        end
        repeat (12) begin
            v = VERT_W'(base + $urandom_range(0, 130));
            send_tri(v + 16'd2, v, v + 16'd1);
            send_read(stored_index());
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items,
                             input bit with_fill, input bit with_pressure);
        int                sent;
        int                pool;
        int                base;
        int                len;
        int                x;
        logic [VERT_W-1:0] a;
        logic [VERT_W-1:0] b;
        logic [VERT_W-1:0] c;
        send_idle = idle_pct;
        recv_stall <= stall_pct;
        if (with_pressure) begin
            pressure_req <= pressure_req + 1;
        end
        if (with_fill) begin
            fill_table();
        end
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 85) begin
                send_clear();
                sent++;
            end
            pool = $urandom_range(3, 40);
            base = $urandom_range(0, 65535 - pool);
            len  = $urandom_range(4, 40);
            repeat (len) begin
                x = $urandom_range(99);
                if (x < 68) begin
                    a = VERT_W'(base + $urandom_range(0, pool - 1));
                    b = VERT_W'(base + $urandom_range(0, pool - 1));
                    c = VERT_W'(base + $urandom_range(0, pool - 1));
                    send_tri(a, b, c);
                    sent++;
                end else if (x < 82) begin
                    send_read(stored_index());
                    sent++;
                end else if (x < 86) begin
                    send_read(INDEX_W'($urandom));
                    sent++;
                end else if (x < 94) begin
                    send_tri(16'($urandom), 16'($urandom), 16'($urandom));
                    sent++;
                end else if (x < 97) begin
                    send_word('{FUNC_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
                                8'($urandom)}, PRED, '0);
                end else begin
                    send_clear();
                    sent++;
                end
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    task automatic check_result(input logic [79:0] word);
        t_result got;
        t_result want;
        got = word[75:0];
        if (pending_results.size() == 0) begin
            $error("output word with no result pending: %h", word);
            n_errors++;
        end else begin
            want = pending_results.pop_front();
            check_field("edge_vert_lo", want.edge_vert_lo, got.edge_vert_lo);
            check_field("edge_vert_hi", want.edge_vert_hi, got.edge_vert_hi);
            check_field("first_face", want.first_face, got.first_face);
            check_field("second_face", want.second_face, got.second_face);
            check_field("edge_total", want.edge_total, got.edge_total);
            check_field("edges_added", want.edges_added, got.edges_added);
            check_field("overflow", want.overflow, got.overflow);
            check_field("zero_pad", 0, word[79:76]);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) begin
            check_result(m_data);
        end
        if ((m_valid && m_ready) || (s_valid && s_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (pressure_req != pressure_seen) begin
            pressure_seen <= pressure_req;
            hold_left     <= HOLD_CYCLES;
            m_ready       <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
        end
        $display("mesh_edge_adjacency_table_unit_test: done, errors");
        $finish;
    end

    initial begin : stimulus
        t_result typed_res;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i]) begin
            typed_res = '{DIRECTED[i].ovf, DIRECTED[i].added, DIRECTED[i].total,
                          DIRECTED[i].f1, DIRECTED[i].f0, DIRECTED[i].hi, DIRECTED[i].lo};
            send_word('{DIRECTED[i].func, DIRECTED[i].vert_a, DIRECTED[i].vert_b,
                        DIRECTED[i].vert_c, DIRECTED[i].edge_index},
                      DIRECTED[i].typed, typed_res);
        end

        run_phase(0, 0, 390, 1'b1, 1'b1);
        run_phase(80, 0, 390, 1'b0, 1'b0);
        run_phase(0, 80, 390, 1'b0, 1'b0);
        run_phase(31, 31, 390, 1'b0, 1'b1);

        s_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0) begin
            $display("mesh_edge_adjacency_table_unit_test: done, clean");
        end else begin
            $display("mesh_edge_adjacency_table_unit_test: done, errors");
        end
        $finish;
    end

endmodule
